FILE: rtl/stbs_pkg.sv
// Package for the sorted-table binary search: sizes, request codes, result type.
package stbs_pkg;

  localparam int unsigned TABLE_DEPTH = 16;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned KEY_W       = 32;
  localparam int unsigned CFG_W       = 5;
  localparam int unsigned CFG_RESET   = 16;
  localparam int unsigned MAX_PROBES  = 5;
  localparam int unsigned CNT_W       = $clog2(MAX_PROBES);

  localparam logic REQ_LOAD   = 1'b0;
  localparam logic REQ_SEARCH = 1'b1;

  typedef struct packed {
    logic signed [KEY_W-1:0] probe_key;
    logic                    found;
    logic [IDX_W-1:0]        found_index;
    logic                    last;
  } res_t;

endpackage

FILE: rtl/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/stbs_engine.sv
// Search sequencer: key table RAM, probe range registers and result generation.
module stbs_engine (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    in_valid_i,
  output logic                                    in_stall_o,
  input  logic                                    req_type_i,
  input  logic [stbs_pkg::IDX_W-1:0]              entry_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0]       search_key_i,
  input  logic signed [stbs_pkg::KEY_W-1:0]       entry_key_i,
  input  logic [stbs_pkg::IDX_W-1:0]              last_index_i,
  input  logic                                    slot_free_i,
  output logic                                    res_push_o,
  output stbs_pkg::res_t                          res_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ACK   = 2'd1;
  localparam logic [1:0] ST_PROBE = 2'd2;

  logic [1:0]                          state_q, state_d;
  logic signed [stbs_pkg::KEY_W-1:0]   key_q, key_d;
  logic [stbs_pkg::IDX_W-1:0]          lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [stbs_pkg::CNT_W-1:0]          cnt_q, cnt_d;

  logic                                ram_we, ram_re;
  logic [stbs_pkg::IDX_W-1:0]          ram_raddr;
  logic [stbs_pkg::KEY_W-1:0]          ram_rdata;
  logic signed [stbs_pkg::KEY_W-1:0]   probe;

  logic                                hit, below, stop_nf, final_probe;
  logic [stbs_pkg::IDX_W-1:0]          nxt_lo, nxt_hi, nxt_mid;
  logic [stbs_pkg::IDX_W:0]            mid_sum;

  stbs_ram #(
    .WIDTH (stbs_pkg::KEY_W),
    .DEPTH (stbs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (entry_index_i),
    .wdata_i (entry_key_i),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign probe = $signed(ram_rdata);

  // Compare and range update for the probe whose data sits on the RAM output
  assign hit   = (probe == key_q);
  assign below = (key_q < probe);

  always_comb begin
    nxt_lo  = lo_q;
    nxt_hi  = hi_q;
    stop_nf = 1'b0;
    if (lo_q == hi_q) begin
      stop_nf = 1'b1;
    end else if (below) begin
      if (mid_q == lo_q) stop_nf = 1'b1;
      else               nxt_hi  = mid_q - 1'b1;
    end else begin
      if (mid_q == hi_q) stop_nf = 1'b1;
      else               nxt_lo  = mid_q + 1'b1;
    end
  end

  assign mid_sum     = {1'b0, nxt_lo} + {1'b0, nxt_hi};
  assign nxt_mid     = mid_sum[stbs_pkg::IDX_W:1];
  assign final_probe = hit || stop_nf ||
                       (cnt_q == stbs_pkg::CNT_W'(stbs_pkg::MAX_PROBES - 1));

  always_comb begin
    state_d    = state_q;
    key_d      = key_q;
    lo_d       = lo_q;
    hi_d       = hi_q;
    mid_d      = mid_q;
    cnt_d      = cnt_q;
    ram_we     = 1'b0;
    ram_re     = 1'b0;
    ram_raddr  = mid_q;
    res_push_o = 1'b0;
    res_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          unique case (req_type_i)
            stbs_pkg::REQ_LOAD: begin
              // 4-bit index always lands inside the table
              ram_we  = 1'b1;
              state_d = ST_ACK;
            end
            stbs_pkg::REQ_SEARCH: begin
              key_d     = search_key_i;
              lo_d      = '0;
              hi_d      = last_index_i;
              mid_d     = last_index_i >> 1;
              cnt_d     = '0;
              ram_re    = 1'b1;
              ram_raddr = mid_d;
              state_d   = ST_PROBE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACK: begin
        if (slot_free_i) begin
          res_push_o = 1'b1;
          res_o.last = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      ST_PROBE: begin
        // Hold here (RAM data held too) while the output slot is full
        if (slot_free_i) begin
          res_push_o      = 1'b1;
          res_o.probe_key = probe;
          res_o.found     = hit;
          res_o.found_index = hit ? mid_q : '0;
          res_o.last      = final_probe;
          if (final_probe) begin
            state_d = ST_IDLE;
          end else begin
            lo_d      = nxt_lo;
            hi_d      = nxt_hi;
            mid_d     = nxt_mid;
            cnt_d     = cnt_q + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = nxt_mid;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    mid_q <= mid_d;
    cnt_q <= cnt_d;
  end

endmodule

FILE: rtl/sorted_table_binary_search.sv
// Top level of the sorted-table binary search: config register, engine and output register.
// Holds a 16-entry table of signed Q16.16 keys in one RAM with a registered read.
// A load item writes one entry and returns one acknowledgement item (key zero, last set).
// A search item runs a binary search over entries 0 .. entries_in_use-1 (0 reads as 1,
// above 16 as 16) and returns one item per probe, carrying the probed key; the final item
// has last set and, on a hit, found and the index. A search makes 1 to 5 probes: one
// RAM read is issued on acceptance, and each probe compares the returned key and issues
// the next read unless it is the final one. Items are taken one at a time; in_stall_o is
// high while an item is in progress. Results pass through a one-deep output register, and
// out_stall_i holds the engine with the pending probe kept on the RAM output. The table is
// not cleared at reset: searching entries never loaded gives undefined keys. entries_in_use
// resets to 16; the user must ensure it is written only while the block is idle, as the
// block itself does not enforce this.
module sorted_table_binary_search (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // input channel
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [stbs_pkg::IDX_W-1:0]        entry_index_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] entry_key_i,
  input  logic signed [stbs_pkg::KEY_W-1:0] search_key_i,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [stbs_pkg::CFG_W-1:0]        cfg_wdata_i,
  // result channel
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [stbs_pkg::KEY_W-1:0] probe_key_o,
  output logic                              found_o,
  output logic [stbs_pkg::IDX_W-1:0]        found_index_o,
  output logic                              last_o
);

  logic [stbs_pkg::CFG_W-1:0] cfg_q;
  logic [stbs_pkg::IDX_W-1:0] last_index;

  logic                       out_valid_q;
  stbs_pkg::res_t             res_q;
  stbs_pkg::res_t             res;
  logic                       res_push;
  logic                       slot_free;

  // entries_in_use register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= stbs_pkg::CFG_W'(stbs_pkg::CFG_RESET);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Highest index searched, with the count clamped to 1 .. TABLE_DEPTH
  always_comb begin
    priority if (cfg_q == '0) begin
      last_index = '0;
    end else if (cfg_q > stbs_pkg::CFG_W'(stbs_pkg::TABLE_DEPTH)) begin
      last_index = stbs_pkg::IDX_W'(stbs_pkg::TABLE_DEPTH - 1);
    end else begin
      last_index = stbs_pkg::IDX_W'(cfg_q - 1'b1);
    end
  end

  // Output slot may take a new item when empty or being emptied this cycle
  assign slot_free = !out_valid_q || !out_stall_i;

  stbs_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .req_type_i    (req_type_i),
    .entry_index_i (entry_index_i),
    .search_key_i  (search_key_i),
    .entry_key_i   (entry_key_i),
    .last_index_i  (last_index),
    .slot_free_i   (slot_free),
    .res_push_o    (res_push),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_push) begin
      res_q <= res;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign probe_key_o   = res_q.probe_key;
  assign found_o       = res_q.found;
  assign found_index_o = res_q.found_index;
  assign last_o        = res_q.last;

  // An accepted item keeps the engine busy in the following cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("engine idle right after accepting an item");

  // Engine never overwrites a result still waiting at the output
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> (!out_valid_q || !out_stall_i))
    else $error("result pushed into a full output slot");

  // Hit is only reported on the final item of a search
  a_found_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> last_o)
    else $error("found set on an item that is not last");

  // After pushing the final item the engine is ready for the next one
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_push && res.last) |=> !in_stall_o)
    else $error("engine still busy after final result");

endmodule
